@@ rtl/core/sps_pkg.sv @@
// Package with shared constants, codes and types of the slot pool free stack.
package sps_pkg;

  localparam int unsigned SLOTS  = 1024;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned OFS_W  = 26;
  localparam int unsigned ADDR_W = 3;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  localparam logic [1:0] CMD_INIT    = 2'd0;
  localparam logic [1:0] CMD_ACQUIRE = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_LOCATE  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_SLOT_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_POP
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]  slot_count;
    logic [SIZE_W-1:0] slot_size;
  } cfg_t;

endpackage

@@ rtl/core/sps_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module sps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sps_cfg.sv @@
// APB register block holding the slot count and the slot size.
module sps_cfg
  import sps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [CNT_W-1:0]  slot_count_q;
  logic [SIZE_W-1:0] slot_size_q;
  logic              wr_en;

  // Registers are word aligned; the low address bits are not decoded.
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= CNT_W'(1024);
      slot_size_q  <= SIZE_W'(2048);
    end else if (wr_en) begin
      if (paddr[2] == REG_SLOT_COUNT) begin
        slot_count_q <= pwdata[CNT_W-1:0];
      end else begin
        slot_size_q <= pwdata[SIZE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_SLOT_COUNT) begin
      prdata = {{(32-CNT_W){1'b0}}, slot_count_q};
    end else begin
      prdata = {{(32-SIZE_W){1'b0}}, slot_size_q};
    end
  end

  assign cfg_o.slot_count = slot_count_q;
  assign cfg_o.slot_size  = slot_size_q;

endmodule

@@ rtl/core/sps_ctrl.sv @@
// Command sequencer: stack pointer, init fill walk, pop wait and result register.
module sps_ctrl
  import sps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [SLOT_W-1:0] slot_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [SLOT_W-1:0] granted_o,
  output logic [OFS_W-1:0]  offset_o,
  output logic [CNT_W-1:0]  free_count_o,
  output logic              ram_we_o,
  output logic [SLOT_W-1:0] ram_waddr_o,
  output logic [SLOT_W-1:0] ram_wdata_o,
  output logic              ram_re_o,
  output logic [SLOT_W-1:0] ram_raddr_o,
  input  logic [SLOT_W-1:0] ram_rdata_i
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  top_q, top_d;
  logic [SLOT_W-1:0] fill_idx_q, fill_idx_d;
  logic [SLOT_W-1:0] fill_last_q, fill_last_d;
  logic              out_valid_q;
  logic [1:0]        status_q, status_d;
  logic [SLOT_W-1:0] granted_q, granted_d;
  logic [OFS_W-1:0]  offset_q, offset_d;
  logic [CNT_W-1:0]  free_q;
  logic              load;
  logic              accept;
  logic [CNT_W-1:0]  eff_n;
  logic              bad_cfg;
  logic              slot_oor;
  logic [CNT_W-1:0]  top_dec;
  logic [OFS_W-1:0]  product;

  assign eff_n    = (cfg_i.slot_count > SLOTS_CNT) ? SLOTS_CNT : cfg_i.slot_count;
  assign bad_cfg  = (eff_n == '0) || (cfg_i.slot_size == '0);
  assign slot_oor = {1'b0, slot_i} >= eff_n;
  assign top_dec  = top_q - CNT_W'(1);
  assign product  = OFS_W'(slot_i) * OFS_W'(cfg_i.slot_size);
  assign accept   = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (command_i == CMD_INIT && !bad_cfg) begin
            state_d = S_FILL;
          end else if (command_i == CMD_ACQUIRE && top_q != '0) begin
            state_d = S_POP;
          end
        end
      end
      S_FILL: begin
        if (fill_idx_q == fill_last_q) begin
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
    top_d       = top_q;
    fill_idx_d  = fill_idx_q;
    fill_last_d = fill_last_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = top_q[SLOT_W-1:0];
    ram_wdata_o = slot_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = top_dec[SLOT_W-1:0];
    load        = 1'b0;
    status_d    = STAT_OK;
    granted_d   = '0;
    offset_d    = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_INIT: begin
              if (bad_cfg) begin
                top_d    = '0;
                status_d = STAT_RANGE;
                load     = 1'b1;
              end else begin
                fill_idx_d  = '0;
                fill_last_d = SLOT_W'(eff_n - CNT_W'(1));
              end
            end
            CMD_ACQUIRE: begin
              if (top_q == '0) begin
                status_d = STAT_EMPTY;
                load     = 1'b1;
              end else begin
                top_d    = top_dec;
                ram_re_o = 1'b1;
              end
            end
            CMD_RELEASE: begin
              load = 1'b1;
              if (slot_oor) begin
                status_d = STAT_RANGE;
              end else if (top_q >= eff_n) begin
                status_d = STAT_FULL;
              end else begin
                ram_we_o = 1'b1;
                top_d    = top_q + CNT_W'(1);
              end
            end
            default: begin
              load = 1'b1;
              if (slot_oor) begin
                status_d = STAT_RANGE;
              end else begin
                offset_d = product;
              end
            end
          endcase
        end
      end
      S_FILL: begin
        // Entry i holds n-1-i, so slot 0 sits on top when the walk ends.
        ram_we_o    = 1'b1;
        ram_waddr_o = fill_idx_q;
        ram_wdata_o = fill_last_q - fill_idx_q;
        fill_idx_d  = fill_idx_q + SLOT_W'(1);
        if (fill_idx_q == fill_last_q) begin
          top_d = {1'b0, fill_last_q} + CNT_W'(1);
          load  = 1'b1;
        end
      end
      S_POP: begin
        granted_d = ram_rdata_i;
        load      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fill_idx_q  <= fill_idx_d;
    fill_last_q <= fill_last_d;
    if (load) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      offset_q  <= offset_d;
      free_q    <= top_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign granted_o    = granted_q;
  assign offset_o     = offset_q;
  assign free_count_o = free_q;

endmodule

@@ rtl/core/slot_pool_free_stack_top.sv @@
// Top level of the slot pool free stack allocator.
//
// A LIFO of free slot numbers held in a 1024 x 10 synchronous RAM, with the
// stack depth in a register. Each input item carries a command in tuser
// (init, acquire, release, locate) and a slot number in tdata; each item
// produces exactly one result item with a status in tuser and the granted
// slot, byte offset and free count in tdata. Items are handled one at a
// time. Release, locate and every error response are loaded into the result
// register on accept and appear in the cycle after it. A successful acquire
// reads the stack RAM through its registered read port and loads the result
// from the pop state. A successful init walks the RAM one write port entry
// per cycle over min(slot_count, 1024) entries; afterwards slot 0 is the
// first slot handed out. The stack contents are not cleared at reset and need
// no clearing pass: after reset the pool is empty, and only entries written
// by init or release are ever popped. A new input item is taken only while
// the sequencer is idle and the result register is either empty or hands its
// item over in the same cycle, so a waiting result holds off the input. The
// slot count and slot size live in APB registers at byte offsets 0 and 4 and
// are used live by init, release and locate; write them only while idle.
module slot_pool_free_stack_top
  import sps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Command stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [9:0] slot, [15:10] zero
  input  logic [1:0]        s_axis_tuser,   // [1:0] command
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,   // [9:0] granted_slot, [35:10] byte_offset,
                                            // [46:36] free_count, [47] zero
  output logic [1:0]        m_axis_tuser    // [1:0] status
);

  cfg_t              cfg;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;
  logic [SLOT_W-1:0] granted;
  logic [OFS_W-1:0]  offset;
  logic [CNT_W-1:0]  free_count;

  sps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The stack itself; one write and one read port per cycle.
  sps_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sps_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .command_i    (s_axis_tuser),
    .slot_i       (s_axis_tdata[SLOT_W-1:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_o     (m_axis_tuser),
    .granted_o    (granted),
    .offset_o     (offset),
    .free_count_o (free_count),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  assign m_axis_tdata = {1'b0, free_count, offset, granted};

endmodule

@@ rtl/core/sps_checker.sv @@
// Port-level checker for the slot pool free stack, bound to the top level.
module sps_checker
  import sps_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The stack never reports more free slots than it can hold.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[46:36] <= SLOTS_CNT)
    else $error("free count above pool size");

  // Failed commands return no slot and no offset.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata[35:0] == '0)
    else $error("error result carries data");

  // An empty report means the pool really is empty.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_EMPTY |-> m_axis_tdata[46:36] == '0)
    else $error("empty reported with free slots");

endmodule

bind slot_pool_free_stack_top sps_checker u_sps_checker (.*);
